// ===== rtl/bapd_pkg.sv =====
// Shared types, constants and register map of the blended-angle PD controller.
`timescale 1ns / 1ps

package bapd_pkg;

  // Field and datapath widths.
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned ERR_W     = 16;
  localparam int unsigned DRIVE_W   = 17;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 56;
  localparam int unsigned CFG_IDX_W = 3;

  // Fixed-point scaling.
  localparam int unsigned TF_FRAC   = 12;
  localparam int unsigned LIM_SHIFT = 24;
  localparam int unsigned OUT_SHIFT = 20;
  localparam logic [ERR_W:0]   ONE_Q12    = 17'd4096;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (OUT_SHIFT - 1));

  // Sequencer.
  localparam int unsigned STEP_W    = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd10;

  localparam int unsigned AXIS_COUNT_DEF = 2;

  // Register reset values.
  localparam logic [GAIN_W-1:0] KP1_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] KD1_RST = 16'd768;
  localparam logic [GAIN_W-1:0] KP2_RST = 16'd1280;
  localparam logic [GAIN_W-1:0] KD2_RST = 16'd0;
  localparam logic [GAIN_W-1:0] TF_RST  = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP1 = 3'd0,
    REG_KD1 = 3'd1,
    REG_KP2 = 3'd2,
    REG_KD2 = 3'd3,
    REG_TF  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP_HI,
    ST_CLAMP_LO,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OPA_W,
    OPA_A,
    OPA_D,
    OPA_PROD,
    OPA_KD1,
    OPA_KD2
  } opa_sel_e;

  typedef enum logic [2:0] {
    OPB_E,
    OPB_KP1,
    OPB_KP2,
    OPB_TF,
    OPB_W,
    OPB_A,
    OPB_HOLD
  } opb_sel_e;

  typedef enum logic [2:0] {
    ACC_KEEP,
    ACC_CLEAR,
    ACC_ADD,
    ACC_ADD_SCALED,
    ACC_CLAMP_HI,
    ACC_CLAMP_LO
  } acc_op_e;

  typedef struct packed {
    opa_sel_e opa;
    opb_sel_e opb;
    acc_op_e  acc_op;
    logic     hold_ld;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] e;
    logic        [ERR_W:0]   a;
    logic signed [ERR_W-1:0] w;
    logic signed [ERR_W:0]   d;
    logic        [GAIN_W-1:0] kp1;
    logic        [GAIN_W-1:0] kd1;
    logic        [GAIN_W-1:0] kp2;
    logic        [GAIN_W-1:0] kd2;
    logic        [GAIN_W-1:0] tf;
  } mac_opnd_t;

endpackage

// ===== rtl/bapd_mac.sv =====
// Shared multiplier with product register, hold register and clamping accumulator.
`timescale 1ns / 1ps

module bapd_mac
  import bapd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  mac_opnd_t               opnd_i,
  input  logic        [ACC_W-1:0] lim_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [MUL_W-1:0]   opa;
  logic signed [MUL_W-1:0]   opb;
  logic signed [2*MUL_W-1:0] prod_full;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [MUL_W-1:0]   hold_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   lim_s;
  logic signed [ACC_W-1:0]   acc_plus_lim;

  always_comb begin
    case (ctrl_i.opa)
      OPA_W:    opa = {{(MUL_W-ERR_W){opnd_i.w[ERR_W-1]}}, opnd_i.w};
      OPA_A:    opa = {{(MUL_W-ERR_W-1){1'b0}}, opnd_i.a};
      OPA_D:    opa = {{(MUL_W-ERR_W-1){opnd_i.d[ERR_W]}}, opnd_i.d};
      OPA_PROD: opa = prod_q[MUL_W-1:0];
      OPA_KD1:  opa = {{(MUL_W-GAIN_W){1'b0}}, opnd_i.kd1};
      OPA_KD2:  opa = {{(MUL_W-GAIN_W){1'b0}}, opnd_i.kd2};
      default:  opa = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.opb)
      OPB_E:    opb = {{(MUL_W-ERR_W){opnd_i.e[ERR_W-1]}}, opnd_i.e};
      OPB_KP1:  opb = {{(MUL_W-GAIN_W){1'b0}}, opnd_i.kp1};
      OPB_KP2:  opb = {{(MUL_W-GAIN_W){1'b0}}, opnd_i.kp2};
      OPB_TF:   opb = {{(MUL_W-GAIN_W){1'b0}}, opnd_i.tf};
      OPB_W:    opb = {{(MUL_W-ERR_W){opnd_i.w[ERR_W-1]}}, opnd_i.w};
      OPB_A:    opb = {{(MUL_W-ERR_W-1){1'b0}}, opnd_i.a};
      OPB_HOLD: opb = hold_q;
      default:  opb = '0;
    endcase
  end

  assign prod_full    = opa * opb;
  assign lim_s        = signed'(lim_i);
  assign acc_plus_lim = acc_q + lim_s;

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ACC_KEEP:       acc_d = acc_q;
      ACC_CLEAR:      acc_d = '0;
      ACC_ADD:        acc_d = acc_q + prod_q[ACC_W-1:0];
      // Floor of product / 2^12 is an arithmetic shift.
      ACC_ADD_SCALED: acc_d = acc_q + {{(ACC_W+TF_FRAC-PROD_W){prod_q[PROD_W-1]}},
                                       prod_q[PROD_W-1:TF_FRAC]};
      ACC_CLAMP_HI: begin
        if (acc_q > lim_s) begin
          acc_d = lim_s;
        end
      end
      ACC_CLAMP_LO: begin
        if (acc_plus_lim[ACC_W-1]) begin
          acc_d = -lim_s;
        end
      end
      default:        acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
      hold_q <= '0;
    end else begin
      prod_q <= prod_full[PROD_W-1:0];
      acc_q  <= acc_d;
      if (ctrl_i.hold_ld) begin
        hold_q <= prod_q[MUL_W-1:0];
      end
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/blended_angle_pd_controller_core.sv =====
// Top level of the blended-angle PD leveling controller.
`timescale 1ns / 1ps

// Leveling PD controller for up to AXIS_COUNT attitude axes. Each accepted item
// carries an axis and a Q4.12 angle error; the block returns one item with the
// same axis and a Q5.12 drive value. The small-error PD term is weighted by
// (1 - |e|) and the large-error term by |e|; both D terms act on the change of
// error since the last item of that axis and are scaled by the loop time
// factor. The sum is limited to +/-(kp1 + kp2), rounded to nearest (ties up),
// and saturated to the 17-bit drive range. Items are processed one at a time:
// a single 33x33 multiplier computes the ten products in turn, and the block
// takes the next item in the cycle after the result is taken. An axis at or
// beyond AXIS_COUNT uses a previous error of zero and leaves the stored errors
// untouched. Gain registers are written through the plain write port and must
// only be changed while the block idles.

module blended_angle_pd_controller_core
  import bapd_pkg::*;
#(
  parameter int unsigned AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [GAIN_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        axis_i,
  input  logic signed [ERR_W-1:0]     angle_error_i,
  // Output channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        axis_out_o,
  output logic signed [DRIVE_W-1:0]   drive_o
);

  // Configuration registers.
  logic [GAIN_W-1:0] kp1_q, kd1_q, kp2_q, kd2_q, tf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp1_q <= KP1_RST;
      kd1_q <= KD1_RST;
      kp2_q <= KP2_RST;
      kd2_q <= KD2_RST;
      tf_q  <= TF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP1: kp1_q <= cfg_wdata_i;
        REG_KD1: kd1_q <= cfg_wdata_i;
        REG_KP2: kp2_q <= cfg_wdata_i;
        REG_KD2: kd2_q <= cfg_wdata_i;
        REG_TF:  tf_q  <= cfg_wdata_i;
        default: ; // Unknown indexes are ignored.
      endcase
    end
  end

  // Sequencer state.
  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Previous error per axis. The error term operands are prepared when the
  // item is accepted, and the stored error is replaced at the same edge.
  logic signed [ERR_W-1:0] prev_err_q [AXIS_COUNT];
  logic signed [ERR_W-1:0] prev_sel;
  logic                    axis_ok;
  logic        [ERR_W:0]   e_ext;
  logic        [ERR_W:0]   a_d;
  logic        [ERR_W:0]   w_full;
  logic        [ERR_W:0]   d_d;

  assign axis_ok = int'(axis_i) < AXIS_COUNT;

  always_comb begin
    prev_sel = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (int'(axis_i) == i) begin
        prev_sel = prev_err_q[i];
      end
    end
  end

  assign e_ext  = {angle_error_i[ERR_W-1], angle_error_i};
  assign a_d    = angle_error_i[ERR_W-1] ? (~e_ext + 1'b1) : e_ext;
  assign w_full = ONE_Q12 - a_d;
  assign d_d    = e_ext - {prev_sel[ERR_W-1], prev_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        prev_err_q[i] <= '0;
      end
    end else if (in_acc && axis_ok) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        if (int'(axis_i) == i) begin
          prev_err_q[i] <= angle_error_i;
        end
      end
    end
  end

  // Operands of the item in work.
  logic signed [ERR_W-1:0] e_q;
  logic        [ERR_W:0]   a_q;
  logic signed [ERR_W-1:0] w_q;
  logic signed [ERR_W:0]   d_q;
  logic                    axis_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q    <= angle_error_i;
      a_q    <= a_d;
      w_q    <= signed'(w_full[ERR_W-1:0]);
      d_q    <= signed'(d_d);
      axis_q <= axis_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL;
      ST_MUL:      if (step_q == STEP_LAST) state_d = ST_CLAMP_HI;
      ST_CLAMP_HI: state_d = ST_CLAMP_LO;
      ST_CLAMP_LO: state_d = ST_ROUND;
      ST_ROUND:    state_d = ST_OUT;
      ST_OUT:      if (out_acc) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Control for the shared multiplier. Each product lands in the product
  // register, where the next step multiplies it again, loads it into the hold
  // register, or adds it into the accumulator:
  //   P1 = (w*e)*kp1, P2 = (a*e)*kp2,
  //   D1 = floor((d*w)*(kd1*tf) / 2^12), D2 = floor((d*a)*(kd2*tf) / 2^12).
  mac_ctrl_t ctrl;

  always_comb begin
    ctrl = '{opa: OPA_W, opb: OPB_E, acc_op: ACC_KEEP, hold_ld: 1'b0};
    case (state_q)
      ST_IDLE:     ctrl.acc_op = ACC_CLEAR;
      ST_MUL: begin
        case (step_q)
          4'd0: begin
            ctrl.opa = OPA_W;
            ctrl.opb = OPB_E;
          end
          4'd1: begin
            ctrl.opa = OPA_PROD;
            ctrl.opb = OPB_KP1;
          end
          4'd2: begin
            ctrl.opa    = OPA_A;
            ctrl.opb    = OPB_E;
            ctrl.acc_op = ACC_ADD;
          end
          4'd3: begin
            ctrl.opa = OPA_PROD;
            ctrl.opb = OPB_KP2;
          end
          4'd4: begin
            ctrl.opa    = OPA_KD1;
            ctrl.opb    = OPB_TF;
            ctrl.acc_op = ACC_ADD;
          end
          4'd5: begin
            ctrl.opa     = OPA_D;
            ctrl.opb     = OPB_W;
            ctrl.hold_ld = 1'b1;
          end
          4'd6: begin
            ctrl.opa = OPA_PROD;
            ctrl.opb = OPB_HOLD;
          end
          4'd7: begin
            ctrl.opa    = OPA_KD2;
            ctrl.opb    = OPB_TF;
            ctrl.acc_op = ACC_ADD_SCALED;
          end
          4'd8: begin
            ctrl.opa     = OPA_D;
            ctrl.opb     = OPB_A;
            ctrl.hold_ld = 1'b1;
          end
          4'd9: begin
            ctrl.opa = OPA_PROD;
            ctrl.opb = OPB_HOLD;
          end
          4'd10:   ctrl.acc_op = ACC_ADD_SCALED;
          default: ctrl.acc_op = ACC_KEEP;
        endcase
      end
      ST_CLAMP_HI: ctrl.acc_op = ACC_CLAMP_HI;
      ST_CLAMP_LO: ctrl.acc_op = ACC_CLAMP_LO;
      default:     ctrl.acc_op = ACC_KEEP;
    endcase
  end

  // Output limit (kp1 + kp2) scaled from Q8.8 gain to the Q32 sum.
  logic [GAIN_W:0]  kp_sum;
  logic [ACC_W-1:0] lim;

  assign kp_sum = {1'b0, kp1_q} + {1'b0, kp2_q};
  assign lim    = {{(ACC_W-GAIN_W-1-LIM_SHIFT){1'b0}}, kp_sum, {LIM_SHIFT{1'b0}}};

  mac_opnd_t               opnd;
  logic signed [ACC_W-1:0] acc;

  assign opnd = '{e: e_q, a: a_q, w: w_q, d: d_q,
                  kp1: kp1_q, kd1: kd1_q, kp2: kp2_q, kd2: kd2_q, tf: tf_q};

  bapd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .opnd_i (opnd),
    .lim_i  (lim),
    .acc_o  (acc)
  );

  // Round to nearest with ties upward, then saturate to the drive range. The
  // value is in range when all bits above the drive field match its sign.
  logic [ACC_W-1:0]           rnd;
  logic [ACC_W-OUT_SHIFT-1:0] rnd_q12;
  logic                       in_range;
  logic signed [DRIVE_W-1:0]  drive_d;
  logic signed [DRIVE_W-1:0]  drive_q;

  assign rnd      = acc + ROUND_BIAS;
  assign rnd_q12  = rnd[ACC_W-1:OUT_SHIFT];
  assign in_range = (&rnd_q12[ACC_W-OUT_SHIFT-1:DRIVE_W-1])
                 || !(|rnd_q12[ACC_W-OUT_SHIFT-1:DRIVE_W-1]);

  always_comb begin
    if (in_range) begin
      drive_d = signed'(rnd_q12[DRIVE_W-1:0]);
    end else if (rnd_q12[ACC_W-OUT_SHIFT-1]) begin
      drive_d = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      drive_q <= drive_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign axis_out_o  = axis_q;
  assign drive_o     = drive_q;

endmodule

// ===== tb/blended_angle_pd_controller_core_test.sv =====
// Self-checking testbench for the blended-angle PD leveling controller core.
`timescale 1ns / 1ps

// The testbench feeds angle-error items into the controller through a queue of
// pending items and checks every drive item that comes back against its own
// fixed-point model of the blended PD law. The model keeps its own copy of the
// gain registers and of the last error per axis, and computes the expected
// drive when an item is accepted, so the order of expectations follows the
// order of acceptance. Runs go through phases: a directed set under the reset
// gains, a directed set under the largest gains (with writes to the unused
// register indexes), one under all-zero gains, then random phases with random
// gains. Between phases the sender holds off until every result has come back
// and the core has settled, and only then are the registers rewritten.

module blended_angle_pd_controller_core_test;
  import bapd_pkg::*;

  // Model constants, all in the scaling of the core's datapath.
  localparam int     AXES          = 2;
  localparam longint Q12_ONE       = 4096;
  localparam int     LIMIT_SHIFT   = 24;
  localparam int     RESULT_SHIFT  = 20;
  localparam longint ROUND_HALF    = 524288;
  localparam longint DRIVE_MAX     = 65535;
  localparam longint DRIVE_MIN     = -65536;
  localparam logic signed [ERR_W-1:0] ERR_MAX = 16'sh7FFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 16'sh8000;

  // Register values after reset.
  localparam logic [GAIN_W-1:0] KP1_INIT = 16'd2560;
  localparam logic [GAIN_W-1:0] KD1_INIT = 16'd768;
  localparam logic [GAIN_W-1:0] KP2_INIT = 16'd1280;
  localparam logic [GAIN_W-1:0] KD2_INIT = 16'd0;
  localparam logic [GAIN_W-1:0] TF_INIT  = 16'd4096;

  // Run control.
  localparam int RANDOM_ITEMS  = 500;
  localparam int MAX_WAIT      = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                    axis;
    logic signed [ERR_W-1:0] err;
  } error_item_t;

  typedef struct packed {
    logic                      axis;
    logic signed [DRIVE_W-1:0] drive;
  } drive_item_t;

  // Clock, reset and the core's inputs, all known from time zero.
  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic        [GAIN_W-1:0]    cfg_wdata_i   = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        axis_i        = 1'b0;
  logic signed [ERR_W-1:0]     angle_error_i = '0;
  logic                        out_ready_i   = 1'b0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic                        axis_out_o;
  logic signed [DRIVE_W-1:0]   drive_o;

  // Model copy of the gain registers and of the stored error per axis.
  logic        [GAIN_W-1:0] gain_kp1 = KP1_INIT;
  logic        [GAIN_W-1:0] gain_kd1 = KD1_INIT;
  logic        [GAIN_W-1:0] gain_kp2 = KP2_INIT;
  logic        [GAIN_W-1:0] gain_kd2 = KD2_INIT;
  logic        [GAIN_W-1:0] gain_tf  = TF_INIT;
  logic signed [ERR_W-1:0]  prev_err [AXES];

  error_item_t             error_items_q [$];
  drive_item_t             drive_expect_q [$];
  error_item_t             next_item;
  drive_item_t             want;
  logic signed [ERR_W-1:0] last_sent [2];

  int unsigned items_outstanding = 0;
  int unsigned mismatch_count    = 0;
  int unsigned stall_cycles      = 0;
  int unsigned send_wait         = 0;
  int unsigned recv_wait         = 0;
  logic        send_wait_drawn   = 1'b0;
  logic        idle_on           = 1'b0;

  blended_angle_pd_controller_core #(
    .AXIS_COUNT(AXES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .axis_i       (axis_i),
    .angle_error_i(angle_error_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .axis_out_o   (axis_out_o),
    .drive_o      (drive_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // floor(x * tf / 2^12), split so that the product never leaves 64 bits.
  function automatic longint tf_scale(input longint x, input longint tf);
    longint hi;
    longint lo;
    hi = x >>> 12;
    lo = x - hi * Q12_ONE;
    return hi * tf + ((lo * tf) >>> 12);
  endfunction

  // Blended PD law for one accepted item. Replaces the stored error of the axis
  // and then appends the expected drive item.
  task automatic predict_drive(input logic ax, input logic signed [ERR_W-1:0] err);
    longint      e;
    longint      a;
    longint      w;
    longint      d;
    longint      sum;
    longint      lim;
    longint      r;
    longint      kp1;
    longint      kd1;
    longint      kp2;
    longint      kd2;
    longint      tf;
    drive_item_t res;
    e   = err;
    kp1 = gain_kp1;
    kd1 = gain_kd1;
    kp2 = gain_kp2;
    kd2 = gain_kd2;
    tf  = gain_tf;
    // An axis the core does not keep sees a previous error of zero.
    d = e;
    if (int'(ax) < AXES) begin
      d = e - longint'(prev_err[ax]);
    end
    a = (e < 0) ? -e : e;
    // The small-error weight goes negative above an error of 1.0 and is kept.
    w = Q12_ONE - a;
    sum = w * e * kp1 + a * e * kp2 + tf_scale(d * w * kd1, tf) + tf_scale(d * a * kd2, tf);
    lim = (kp1 + kp2) <<< LIMIT_SHIFT;
    if (sum > lim) begin
      sum = lim;
    end
    if (sum < -lim) begin
      sum = -lim;
    end
    // Round to nearest with ties upward, then saturate to the drive field.
    r = (sum + ROUND_HALF) >>> RESULT_SHIFT;
    if (r > DRIVE_MAX) begin
      r = DRIVE_MAX;
    end
    if (r < DRIVE_MIN) begin
      r = DRIVE_MIN;
    end
    if (int'(ax) < AXES) begin
      prev_err[ax] = err;
    end
    res.axis  = ax;
    res.drive = DRIVE_W'(r);
    drive_expect_q.push_back(res);
  endtask

  task automatic queue_item(input logic ax, input logic signed [ERR_W-1:0] err);
    error_item_t item;
    item.axis = ax;
    item.err  = err;
    error_items_q.push_back(item);
    last_sent[ax] = err;
    items_outstanding++;
  endtask

  // One register write: the enable is high for exactly one clock edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_KP1: gain_kp1 = value;
      REG_KD1: gain_kd1 = value;
      REG_KP2: gain_kp2 = value;
      REG_KD2: gain_kd2 = value;
      REG_TF:  gain_tf  = value;
      default: ;
    endcase
  endtask

  task automatic write_all_gains(input logic [GAIN_W-1:0] kp1, input logic [GAIN_W-1:0] kd1,
                                 input logic [GAIN_W-1:0] kp2, input logic [GAIN_W-1:0] kd2,
                                 input logic [GAIN_W-1:0] tf);
    write_reg(REG_KP1, kp1);
    write_reg(REG_KD1, kd1);
    write_reg(REG_KP2, kp2);
    write_reg(REG_KD2, kd2);
    write_reg(REG_TF, tf);
  endtask

  // Holds the sender off until every queued item has produced its result, then
  // lets the core run out its sequencer before anything else happens.
  task automatic wait_idle();
    while (items_outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return GAIN_W'($urandom_range(0, 4095));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Sender: raises valid after the drawn number of idle cycles and holds the
  // item steady until it is accepted. The expected drive is computed at the
  // accepting edge, with the gains in force at that moment.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      send_wait_drawn = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_drive(axis_i, angle_error_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (error_items_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          if (!send_wait_drawn) begin
            send_wait       = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            send_wait_drawn = 1'b1;
          end
          if (send_wait == 0) begin
            next_item       = error_items_q.pop_front();
            in_valid_i      <= 1'b1;
            axis_i          <= next_item.axis;
            angle_error_i   <= next_item.err;
            send_wait_drawn = 1'b0;
          end else begin
            send_wait--;
            in_valid_i <= 1'b0;
          end
        end
      end
    end
  end

  // Receiver: after each taken item, ready drops for the drawn number of
  // cycles. Every taken item is compared with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected drive item: axis %0d drive %0d", axis_out_o, drive_o);
          end
        end else begin
          want = drive_expect_q.pop_front();
          items_outstanding--;
          if (want.axis !== axis_out_o || want.drive !== drive_o) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("drive mismatch: expected axis %0d drive %0d, got axis %0d drive %0d",
                       want.axis, want.drive, axis_out_o, drive_o);
            end
          end
        end
        recv_wait = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (recv_wait == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("blended_angle_pd_controller_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                      remaining;
    int                      chunk;
    int                      sel;
    logic                    ax;
    logic signed [ERR_W-1:0] err;
    prev_err[0]  = '0;
    prev_err[1]  = '0;
    last_sent[0] = '0;
    last_sent[1] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains, no idling: zero error, the unit points where the blend
    // weights swap over, just beyond them where the small-error weight turns
    // negative, the field extremes, and a full-scale swing on one axis.
    idle_on = 1'b0;
    queue_item(1'b0, 16'sd0);
    queue_item(1'b0, 16'sd4096);
    queue_item(1'b0, -16'sd4096);
    queue_item(1'b1, 16'sd2048);
    queue_item(1'b1, -16'sd2048);
    queue_item(1'b0, ERR_MAX);
    queue_item(1'b0, ERR_MIN);
    queue_item(1'b1, 16'sd4097);
    queue_item(1'b1, -16'sd4097);
    queue_item(1'b1, 16'sd1);
    queue_item(1'b1, -16'sd1);
    queue_item(1'b0, 16'sd0);
    queue_item(1'b1, 16'sd16384);
    queue_item(1'b1, 16'sd0);
    wait_idle();

    // Largest gains and time factor: the limit sits far above the drive range,
    // so full-scale swings saturate the drive both ways. Writes to the unused
    // register indexes must leave the gains alone.
    idle_on = 1'b1;
    write_all_gains('1, '1, '1, '1, '1);
    for (int idx = int'(REG_TF) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), GAIN_W'($urandom));
    end
    queue_item(1'b0, ERR_MAX);
    queue_item(1'b0, ERR_MIN);
    queue_item(1'b0, ERR_MAX);
    queue_item(1'b1, ERR_MIN);
    queue_item(1'b1, 16'sd4096);
    queue_item(1'b1, 16'sd0);
    wait_idle();

    // All registers zero: the limit collapses and the drive must be zero.
    write_all_gains('0, '0, '0, '0, '0);
    queue_item(1'b0, 16'sd12345);
    queue_item(1'b1, -16'sd20000);
    wait_idle();

    // Random phases, each under fresh gains. Most errors either stay within 1.25
    // of zero or drift slowly from the last error of the axis, so the D terms
    // see small steps as in closed-loop use; the rest are full-range values and
    // extremes.
    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      write_all_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'(int'(REG_TF) + 1 + int'($urandom_range(0, 2))),
                  GAIN_W'($urandom));
      end
      idle_on = ($urandom_range(0, 3) != 0);
      chunk   = int'($urandom_range(40, 100));
      if (chunk > remaining) begin
        chunk = remaining;
      end
      for (int n = 0; n < chunk; n++) begin
        ax  = 1'($urandom_range(0, 1));
        sel = int'($urandom_range(0, 9));
        if (sel < 3) begin
          err = ERR_W'($urandom);
        end else if (sel < 5) begin
          err = ERR_W'(int'($urandom_range(0, 10240)) - 5120);
        end else if (sel < 9) begin
          err = last_sent[ax] + ERR_W'(int'($urandom_range(0, 128)) - 64);
        end else begin
          case ($urandom_range(0, 4))
            0:       err = ERR_MAX;
            1:       err = ERR_MIN;
            2:       err = 16'sd4096;
            3:       err = -16'sd4096;
            default: err = 16'sd0;
          endcase
        end
        queue_item(ax, err);
      end
      remaining -= chunk;
      wait_idle();
    end

    if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
      $display("blended_angle_pd_controller_core test passed");
    end else begin
      $display("blended_angle_pd_controller_core test failed");
    end
    $finish;
  end

endmodule
